// ===== hw/rtl/dtcs_pkg.sv =====
package dtcs_pkg;

   localparam int ADDR_W      = 64;
   localparam int SIZE_W      = 32;
   localparam int CSIZE_W     = 24;
   localparam int IDX_W       = 6;
   localparam int TASK_W      = 3;
   localparam int WORD_W      = 64;
   localparam int BYTE_W      = 8;
   localparam int MAX_ENTRIES = 64;

   localparam logic [CSIZE_W-1:0] CHUNK_MAX  = 24'hFFFFFF;
   localparam logic [SIZE_W-1:0]  SIZE_LIMIT = 32'd1073741760;

   localparam logic [TASK_W-1:0] TASK_COPY = 3'h0;
   localparam logic [TASK_W-1:0] TASK_FILL = 3'h7;

   localparam logic OP_COPY = 1'b0;
   localparam logic OP_FILL = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [1:0] {
      KIND_REJECT,
      KIND_SINGLE,
      KIND_LIST
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic                fill;
      logic [ADDR_W-1:0]   source_addr;
      logic [ADDR_W-1:0]   dest_addr;
      logic [SIZE_W-1:0]   src_size;
      logic [SIZE_W-1:0]   dst_size;
      logic [SIZE_W-1:0]   bound;
      logic [BYTE_W-1:0]   fill_byte;
      logic [IDX_W-1:0]    last_idx;
   } job_type;

endpackage

// ===== hw/rtl/dtcs_classify.sv =====
module dtcs_classify
   import dtcs_pkg::*;
(
   input  logic                op,
   input  logic [ADDR_W-1:0]   source_addr,
   input  logic [SIZE_W-1:0]   src_size,
   input  logic [ADDR_W-1:0]   dest_addr,
   input  logic [SIZE_W-1:0]   dst_size,
   input  logic [BYTE_W-1:0]   fill_byte,
   output job_type             job
);

   logic                  fill;
   logic [SIZE_W-1:0]     bound;
   logic [7:0]            quot;
   logic [CSIZE_W:0]      rem_raw;
   logic                  rem_ge;
   logic [CSIZE_W:0]      rem_fix;
   logic [8:0]            quot_fix;
   logic [8:0]            n_entries;

   // ceil(bound / CHUNK_MAX) with CHUNK_MAX = 2^24 - 1
   always_comb begin
      fill      = (op == OP_FILL);
      bound     = fill ? dst_size : src_size;
      quot      = bound[SIZE_W-1:CSIZE_W];
      rem_raw   = {1'b0, bound[CSIZE_W-1:0]} + {17'b0, quot};
      rem_ge    = (rem_raw >= {1'b0, CHUNK_MAX});
      rem_fix   = rem_ge ? (rem_raw - {1'b0, CHUNK_MAX}) : rem_raw;
      quot_fix  = {1'b0, quot} + {8'b0, rem_ge};
      n_entries = quot_fix + {8'b0, (rem_fix != '0)};

      job.fill        = fill;
      job.source_addr = source_addr;
      job.dest_addr   = dest_addr;
      job.src_size    = src_size;
      job.dst_size    = dst_size;
      job.bound       = bound;
      job.fill_byte   = fill_byte;
      job.last_idx    = '0;

      if (dst_size > SIZE_LIMIT) begin
         job.kind = KIND_REJECT;
      end else if (dst_size <= {8'b0, CHUNK_MAX}) begin
         job.kind = KIND_SINGLE;
      end else if (bound == '0 || n_entries > 9'(MAX_ENTRIES)) begin
         job.kind = KIND_REJECT;
      end else begin
         job.kind     = KIND_LIST;
         job.last_idx = IDX_W'(n_entries - 9'd1);
      end
   end

endmodule

// ===== hw/rtl/dtcs_walker.sv =====
module dtcs_walker
   import dtcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  job_type              job,
   output logic                 job_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_status,
   output logic                 rsp_multi,
   output logic [TASK_W-1:0]    rsp_task_ext,
   output logic [ADDR_W-1:0]    rsp_chunk_source_addr,
   output logic [CSIZE_W-1:0]   rsp_chunk_src_size,
   output logic [ADDR_W-1:0]    rsp_chunk_dest_addr,
   output logic [CSIZE_W-1:0]   rsp_chunk_dst_size,
   output logic [WORD_W-1:0]    rsp_fill_word,
   output logic [IDX_W-1:0]     rsp_entry_count_less_one,
   output logic                 rsp_last
);

   logic                 busy_ff, busy_in;
   job_type              job_ff, job_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 status_ff, status_in;
   logic                 multi_ff, multi_in;
   logic [TASK_W-1:0]    task_ff, task_in;
   logic [ADDR_W-1:0]    saddr_ff, saddr_in;
   logic [CSIZE_W-1:0]   ssize_ff, ssize_in;
   logic [ADDR_W-1:0]    daddr_ff, daddr_in;
   logic [CSIZE_W-1:0]   dsize_ff, dsize_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [IDX_W-1:0]     count_ff, count_in;
   logic                 last_ff, last_in;

   logic                 out_free;
   logic                 advance;
   logic                 final_entry;
   logic                 take;
   logic [29:0]          offset;
   logic [30:0]          chunk_end;
   logic                 full_chunk;
   logic [SIZE_W-1:0]    src_rem;
   logic [SIZE_W-1:0]    dst_rem;
   logic [CSIZE_W-1:0]   copy_dst;
   logic [TASK_W-1:0]    task_code;
   logic [WORD_W-1:0]    word;

   always_comb begin
      out_free    = !rsp_valid_ff || !rsp_stall;
      advance     = busy_ff && out_free;
      final_entry = (idx_ff == job_ff.last_idx);
      job_stall   = busy_ff && !(advance && final_entry);
      take        = job_valid && !job_stall;

      busy_in = busy_ff;
      job_in  = job_ff;
      idx_in  = idx_ff;
      if (take) begin
         busy_in = 1'b1;
         job_in  = job;
         idx_in  = '0;
      end else if (advance) begin
         if (final_entry) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   // per-entry geometry
   always_comb begin
      offset     = {idx_ff, 24'b0} - {24'b0, idx_ff};
      chunk_end  = {1'b0, offset} + {7'b0, CHUNK_MAX};
      full_chunk = ({1'b0, chunk_end} <= job_ff.bound);
      src_rem    = job_ff.src_size - {2'b0, offset};
      dst_rem    = job_ff.dst_size - {2'b0, offset};
      if (job_ff.dst_size <= {2'b0, offset}) begin
         copy_dst = '0;
      end else if (dst_rem > {8'b0, CHUNK_MAX}) begin
         copy_dst = CHUNK_MAX;
      end else begin
         copy_dst = dst_rem[CSIZE_W-1:0];
      end
      task_code = job_ff.fill ? TASK_FILL : TASK_COPY;
      word      = job_ff.fill ? {8{job_ff.fill_byte}} : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      multi_in     = multi_ff;
      task_in      = task_ff;
      saddr_in     = saddr_ff;
      ssize_in     = ssize_ff;
      daddr_in     = daddr_ff;
      dsize_in     = dsize_ff;
      word_in      = word_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      if (out_free) begin
         rsp_valid_in = busy_ff;
         status_in    = STATUS_OK;
         multi_in     = 1'b0;
         task_in      = '0;
         saddr_in     = '0;
         ssize_in     = '0;
         daddr_in     = '0;
         dsize_in     = '0;
         word_in      = '0;
         count_in     = '0;
         last_in      = final_entry;
         case (job_ff.kind)
            KIND_REJECT: begin
               status_in = STATUS_REJECT;
            end
            KIND_SINGLE: begin
               task_in  = task_code;
               saddr_in = job_ff.fill ? '0 : job_ff.source_addr;
               ssize_in = job_ff.fill ? '0 : job_ff.dst_size[CSIZE_W-1:0];
               daddr_in = job_ff.dest_addr;
               dsize_in = job_ff.dst_size[CSIZE_W-1:0];
               word_in  = word;
            end
            KIND_LIST: begin
               multi_in = 1'b1;
               task_in  = task_code;
               saddr_in = job_ff.fill ? '0 : job_ff.source_addr + {34'b0, offset};
               daddr_in = job_ff.dest_addr + {34'b0, offset};
               word_in  = word;
               count_in = job_ff.last_idx;
               if (full_chunk) begin
                  ssize_in = job_ff.fill ? '0 : CHUNK_MAX;
                  dsize_in = CHUNK_MAX;
               end else if (job_ff.fill) begin
                  dsize_in = dst_rem[CSIZE_W-1:0];
               end else begin
                  ssize_in = src_rem[CSIZE_W-1:0];
                  dsize_in = copy_dst;
               end
            end
            default: begin
               status_in = STATUS_REJECT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      status_ff <= status_in;
      multi_ff  <= multi_in;
      task_ff   <= task_in;
      saddr_ff  <= saddr_in;
      ssize_ff  <= ssize_in;
      daddr_ff  <= daddr_in;
      dsize_ff  <= dsize_in;
      word_ff   <= word_in;
      count_ff  <= count_in;
      last_ff   <= last_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = status_ff;
   assign rsp_multi                = multi_ff;
   assign rsp_task_ext             = task_ff;
   assign rsp_chunk_source_addr    = saddr_ff;
   assign rsp_chunk_src_size       = ssize_ff;
   assign rsp_chunk_dest_addr      = daddr_ff;
   assign rsp_chunk_dst_size       = dsize_ff;
   assign rsp_fill_word            = word_ff;
   assign rsp_entry_count_less_one = count_ff;
   assign rsp_last                 = last_ff;

endmodule

// ===== hw/rtl/dma_transfer_chunk_splitter.sv =====
// Splits one copy or fill request into DMA descriptors. A request whose destination
// size fits in one chunk (16777215 bytes) gives one single descriptor; a larger one
// gives a chunk list of up to 64 entries, one per cycle while results do not stall,
// each with stepped addresses, per-side sizes, the entry count and a last mark.
// Oversized requests, and list requests with an empty source, give one result with
// status set. Each request is classified as it is accepted and then held in a job
// register while an entry counter walks its 1 to 64 results into the result
// register; the next request is accepted when the block is idle or in the cycle
// its predecessor's final entry moves there; a stalled result holds off that move.
module dma_transfer_chunk_splitter
   import dtcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_op,
   input  logic [ADDR_W-1:0]    req_source_addr,
   input  logic [SIZE_W-1:0]    req_src_size,
   input  logic [ADDR_W-1:0]    req_dest_addr,
   input  logic [SIZE_W-1:0]    req_dst_size,
   input  logic [BYTE_W-1:0]    req_fill_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_status,
   output logic                 rsp_multi,
   output logic [TASK_W-1:0]    rsp_task_ext,
   output logic [ADDR_W-1:0]    rsp_chunk_source_addr,
   output logic [CSIZE_W-1:0]   rsp_chunk_src_size,
   output logic [ADDR_W-1:0]    rsp_chunk_dest_addr,
   output logic [CSIZE_W-1:0]   rsp_chunk_dst_size,
   output logic [WORD_W-1:0]    rsp_fill_word,
   output logic [IDX_W-1:0]     rsp_entry_count_less_one,
   output logic                 rsp_last
);

   job_type job;

   dtcs_classify u_classify (
      .op          (req_op),
      .source_addr (req_source_addr),
      .src_size    (req_src_size),
      .dest_addr   (req_dest_addr),
      .dst_size    (req_dst_size),
      .fill_byte   (req_fill_byte),
      .job         (job)
   );

   dtcs_walker u_walker (
      .clock                    (clock),
      .reset                    (reset),
      .job_valid                (req_valid),
      .job                      (job),
      .job_stall                (req_stall),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_status               (rsp_status),
      .rsp_multi                (rsp_multi),
      .rsp_task_ext             (rsp_task_ext),
      .rsp_chunk_source_addr    (rsp_chunk_source_addr),
      .rsp_chunk_src_size       (rsp_chunk_src_size),
      .rsp_chunk_dest_addr      (rsp_chunk_dest_addr),
      .rsp_chunk_dst_size       (rsp_chunk_dst_size),
      .rsp_fill_word            (rsp_fill_word),
      .rsp_entry_count_less_one (rsp_entry_count_less_one),
      .rsp_last                 (rsp_last)
   );

endmodule

// ===== tb/tb_dma_transfer_chunk_splitter.sv =====
`timescale 1ns / 1ps

module tb_dma_transfer_chunk_splitter
   import dtcs_pkg::*;
();

   localparam int          CYCLE_LIMIT = 1000000;
   localparam logic [31:0] CHUNK32     = 32'(CHUNK_MAX);

   typedef struct packed {
      logic               status;
      logic               multi;
      logic [TASK_W-1:0]  task_ext;
      logic [ADDR_W-1:0]  source_addr;
      logic [CSIZE_W-1:0] src_size;
      logic [ADDR_W-1:0]  dest_addr;
      logic [CSIZE_W-1:0] dst_size;
      logic [WORD_W-1:0]  fill_word;
      logic [IDX_W-1:0]   count_less_one;
      logic               last;
   } descriptor_type;

   class descriptor_scoreboard;
      descriptor_type expected_descriptors[$];
      int errors = 0;

      function int pending();
         return expected_descriptors.size();
      endfunction

      function void push_reject();
         descriptor_type d;
         d = '0;
         d.status = STATUS_REJECT;
         d.last = 1'b1;
         expected_descriptors.push_back(d);
      endfunction

      // work out the descriptors one accepted request gives
      function void note_request(logic op, logic [63:0] saddr, logic [31:0] ssize,
                                 logic [63:0] daddr, logic [31:0] dsize, logic [7:0] fb);
         descriptor_type d;
         logic [63:0] chunk, bound, count, off, s_sz, d_sz;
         bit fill;
         chunk = 64'(CHUNK_MAX);
         fill = (op == OP_FILL);
         d = '0;
         d.task_ext = fill ? TASK_FILL : TASK_COPY;
         d.fill_word = fill ? {8{fb}} : '0;
         d.status = STATUS_OK;
         if (dsize > SIZE_LIMIT) begin
            push_reject();
            return;
         end
         if (dsize <= 32'(CHUNK_MAX)) begin
            d.source_addr = fill ? '0 : saddr;
            d.src_size = fill ? '0 : dsize[CSIZE_W-1:0];
            d.dest_addr = daddr;
            d.dst_size = dsize[CSIZE_W-1:0];
            d.last = 1'b1;
            expected_descriptors.push_back(d);
            return;
         end
         bound = fill ? 64'(dsize) : 64'(ssize);
         count = (bound + chunk - 1) / chunk;
         if (bound == 0 || count > 64'(MAX_ENTRIES)) begin
            push_reject();
            return;
         end
         d.multi = 1'b1;
         d.count_less_one = IDX_W'(count - 1);
         for (int i = 0; i < int'(count); i++) begin
            off = 64'(i) * chunk;
            if (off + chunk <= bound) begin
               s_sz = chunk;
               d_sz = chunk;
            end else if (fill) begin
               s_sz = 0;
               d_sz = 64'(dsize) - off;
            end else begin
               s_sz = 64'(ssize) - off;
               d_sz = (64'(dsize) > off) ? 64'(dsize) - off : 0;
               if (d_sz > chunk) d_sz = chunk;
            end
            d.source_addr = fill ? '0 : saddr + off;
            d.src_size = fill ? '0 : s_sz[CSIZE_W-1:0];
            d.dest_addr = daddr + off;
            d.dst_size = d_sz[CSIZE_W-1:0];
            d.last = (i + 1 == int'(count));
            expected_descriptors.push_back(d);
         end
      endfunction

      function void compare_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
         if (exp_val !== got_val) begin
            $error("%s expected %h actual %h", name, exp_val, got_val);
            errors++;
         end
      endfunction

      function void check_result(descriptor_type got);
         descriptor_type e;
         if (expected_descriptors.size() == 0) begin
            $error("unexpected descriptor %p", got);
            errors++;
            return;
         end
         e = expected_descriptors.pop_front();
         compare_field("status", e.status, got.status);
         compare_field("multi", e.multi, got.multi);
         compare_field("task_ext", e.task_ext, got.task_ext);
         compare_field("chunk_source_addr", e.source_addr, got.source_addr);
         compare_field("chunk_src_size", e.src_size, got.src_size);
         compare_field("chunk_dest_addr", e.dest_addr, got.dest_addr);
         compare_field("chunk_dst_size", e.dst_size, got.dst_size);
         compare_field("fill_word", e.fill_word, got.fill_word);
         compare_field("entry_count_less_one", e.count_less_one, got.count_less_one);
         compare_field("last", e.last, got.last);
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_op = OP_COPY;
   logic [ADDR_W-1:0]   req_source_addr = '0;
   logic [SIZE_W-1:0]   req_src_size = '0;
   logic [ADDR_W-1:0]   req_dest_addr = '0;
   logic [SIZE_W-1:0]   req_dst_size = '0;
   logic [BYTE_W-1:0]   req_fill_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_status;
   logic                rsp_multi;
   logic [TASK_W-1:0]   rsp_task_ext;
   logic [ADDR_W-1:0]   rsp_chunk_source_addr;
   logic [CSIZE_W-1:0]  rsp_chunk_src_size;
   logic [ADDR_W-1:0]   rsp_chunk_dest_addr;
   logic [CSIZE_W-1:0]  rsp_chunk_dst_size;
   logic [WORD_W-1:0]   rsp_fill_word;
   logic [IDX_W-1:0]    rsp_entry_count_less_one;
   logic                rsp_last;

   descriptor_scoreboard sb = new();
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int rsp_wait = 0;

   dma_transfer_chunk_splitter dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_op                   (req_op),
      .req_source_addr          (req_source_addr),
      .req_src_size             (req_src_size),
      .req_dest_addr            (req_dest_addr),
      .req_dst_size             (req_dst_size),
      .req_fill_byte            (req_fill_byte),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_status               (rsp_status),
      .rsp_multi                (rsp_multi),
      .rsp_task_ext             (rsp_task_ext),
      .rsp_chunk_source_addr    (rsp_chunk_source_addr),
      .rsp_chunk_src_size       (rsp_chunk_src_size),
      .rsp_chunk_dest_addr      (rsp_chunk_dest_addr),
      .rsp_chunk_dst_size       (rsp_chunk_dst_size),
      .rsp_fill_word            (rsp_fill_word),
      .rsp_entry_count_less_one (rsp_entry_count_less_one),
      .rsp_last                 (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_dma_transfer_chunk_splitter failed");
      $finish;
   end

   // result side: check each accepted descriptor, then stall for a random while
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result('{rsp_status, rsp_multi, rsp_task_ext, rsp_chunk_source_addr,
                           rsp_chunk_src_size, rsp_chunk_dest_addr, rsp_chunk_dst_size,
                           rsp_fill_word, rsp_entry_count_less_one, rsp_last});
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         rsp_wait = rsp_burst ? 0 : $urandom_range(0, 6);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_stall <= (rsp_wait > 0);
   end

   task automatic send_request(logic op, logic [63:0] saddr, logic [31:0] ssize,
                               logic [63:0] daddr, logic [31:0] dsize, logic [7:0] fb);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 29) == 0) req_burst = !req_burst;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_source_addr <= saddr;
      req_src_size <= ssize;
      req_dest_addr <= daddr;
      req_dst_size <= dsize;
      req_fill_byte <= fb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, saddr, ssize, daddr, dsize, fb);
   endtask

   task automatic send_random_request();
      logic        op;
      logic [63:0] saddr, daddr;
      logic [31:0] ssize, dsize;
      logic [7:0]  fb;
      int          kind, n;
      op = 1'($urandom_range(0, 1));
      fb = 8'($urandom);
      saddr = {$urandom, $urandom};
      daddr = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) daddr[63:32] = '1;
      if ($urandom_range(0, 9) == 0) saddr[63:32] = '1;
      ssize = $urandom;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         // single descriptor
         dsize = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64)
                                              : $urandom_range(0, CHUNK32);
      end else if (kind < 85) begin
         // chunk list, mostly short
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 64) : $urandom_range(1, 4);
         if (op == OP_FILL) begin
            if (n < 2) n = 2;
            dsize = (n - 1) * CHUNK32 + $urandom_range(1, CHUNK32);
         end else begin
            ssize = (n - 1) * CHUNK32 + $urandom_range(1, CHUNK32);
            case ($urandom_range(0, 2))
               0: dsize = (ssize > CHUNK32) ? ssize : CHUNK32 + 1;
               1: dsize = $urandom_range(CHUNK32 + 1, 5 * CHUNK32);
               default: dsize = $urandom_range(CHUNK32 + 1, SIZE_LIMIT);
            endcase
         end
      end else if (kind < 95) begin
         // rejected requests
         case ($urandom_range(0, 2))
            0: dsize = $urandom_range(SIZE_LIMIT + 1, 32'hFFFFFFFF);
            1: begin
               op = OP_COPY;
               ssize = 0;
               dsize = $urandom_range(CHUNK32 + 1, SIZE_LIMIT);
            end
            default: begin
               op = OP_COPY;
               ssize = $urandom_range(SIZE_LIMIT + 1, 32'hFFFFFFFF);
               dsize = $urandom_range(CHUNK32 + 1, SIZE_LIMIT);
            end
         endcase
      end else begin
         dsize = $urandom;
      end
      send_request(op, saddr, ssize, daddr, dsize, fb);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_COPY, '0, '0, '0, '0, 8'h00);
      send_request(OP_COPY, '1, '1, '1, CHUNK32, 8'hFF);
      send_request(OP_FILL, '1, '1, 64'h0123456789abcdef, '0, 8'hFF);
      send_request(OP_FILL, '0, '0, '1, CHUNK32, 8'hA5);
      send_request(OP_COPY, 64'h5, '0, 64'h9, CHUNK32 + 1, 8'h00);
      send_request(OP_COPY, 64'h1000, SIZE_LIMIT, 64'h2000, SIZE_LIMIT, 8'h00);
      send_request(OP_COPY, 64'h1000, SIZE_LIMIT + 1, 64'h2000, SIZE_LIMIT, 8'h00);
      send_request(OP_COPY, 64'h1000, '1, 64'h2000, CHUNK32 + 1, 8'h00);
      send_request(OP_COPY, '1, '1, '1, SIZE_LIMIT + 1, 8'hFF);
      send_request(OP_FILL, '1, '1, '1, '1, 8'hFF);
      send_request(OP_FILL, '0, '0, 64'hFFFFFFFF_FF000000, SIZE_LIMIT, 8'h5A);
      send_request(OP_FILL, '0, '0, 64'h4000, CHUNK32 + 1, 8'h01);
      send_request(OP_COPY, 64'h3, 32'd1, 64'h7, CHUNK32 + 1, 8'h00);
      send_request(OP_COPY, 64'h100, 3 * CHUNK32 + 5, 64'h200, CHUNK32 + 1, 8'h00);
      send_request(OP_COPY, 64'h100, CHUNK32 + 10, 64'h200, 3 * CHUNK32, 8'h00);
      send_request(OP_COPY, 64'hFFFFFFFF_FFFFFFFC, 2 * CHUNK32, '1, 2 * CHUNK32, 8'h00);
      send_request(OP_FILL, 64'hFFFF, 32'h12345678, 64'h8000, SIZE_LIMIT - 1, 8'h80);
      send_request(OP_COPY, 64'h8000000000000000, 32'h80000000, 64'h10, 32'h7FFFFFFF,
                   8'h00);

      for (int i = 0; i < 460; i++) begin
         if ((i == 150 || i == 330) && sb.pending() != 0) begin
            // hold off until every outstanding descriptor has drained
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         send_random_request();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_dma_transfer_chunk_splitter passed");
      end else begin
         $display("tb_dma_transfer_chunk_splitter failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/dtcs_pkg.sv
hw/rtl/dtcs_classify.sv
hw/rtl/dtcs_walker.sv
hw/rtl/dma_transfer_chunk_splitter.sv
tb/tb_dma_transfer_chunk_splitter.sv
